// File: hw/rtl/block_run_free_list_allocator_macros.svh
// Assertion macros used by the allocator top module.
`ifndef BLOCK_RUN_FREE_LIST_ALLOCATOR_MACROS_SVH
`define BLOCK_RUN_FREE_LIST_ALLOCATOR_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define BFL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define BFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bfl_pkg.sv
`timescale 1ns / 1ps

package bfl_pkg;

    localparam int MAX_BLOCKS       = 1024;
    localparam int DESCRIPTOR_BYTES = 4;
    localparam int RUN_LIMIT        = 65535;

    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);
    localparam int UNIT_W     = 16;
    localparam int REGION_W   = 32;
    localparam int COUNT_W    = 11;
    localparam int LEN_W      = 32;
    localparam int REL_W      = 10;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int WIDE_W = (LINK_W > COUNT_W) ? LINK_W : COUNT_W;
    localparam int SUM_W  = ((WIDE_W > REL_W) ? WIDE_W : REL_W) + 1;
    localparam int CAP_W  = LINK_W + UNIT_W;
    localparam int DIV_W  = IDX_W + UNIT_W;
    localparam int K_W    = $clog2(IDX_W + 1);
    localparam int RUN_W  = LINK_W + 1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

    localparam logic [UNIT_W-1:0]   UNIT_RESET   = 16'd16;
    localparam logic [REGION_W-1:0] REGION_RESET = 32'd16384;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 11'd1024;

    typedef struct packed {
        logic             kind;
        logic [LEN_W-1:0] length_bytes;
        logic [REL_W-1:0] release_index;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [REL_W-1:0]   run_start;
        logic [TOTAL_W-1:0] bytes_in_use;
    } rsp_t;

    typedef struct packed {
        logic [UNIT_W-1:0]   unit_bytes;
        logic [REGION_W-1:0] region_bytes;
        logic [LINK_W-1:0]   eff_count;
    } cfg_t;

endpackage

// File: hw/rtl/bfl_ram.sv
`timescale 1ns / 1ps

module bfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/bfl_cfg.sv
`timescale 1ns / 1ps

module bfl_cfg
    import bfl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  regs
);

    logic [UNIT_W-1:0]   unit_reg;
    logic [REGION_W-1:0] region_reg;
    logic [COUNT_W-1:0]  count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg   <= UNIT_RESET;
            region_reg <= REGION_RESET;
            count_reg  <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_UNIT:   unit_reg   <= cfg_data[UNIT_W-1:0];
                CFG_REGION: region_reg <= cfg_data[REGION_W-1:0];
                CFG_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // The usable block count is capped at the size of the link memory.
    always_comb
    begin
        regs.unit_bytes   = unit_reg;
        regs.region_bytes = region_reg;
        if (SUM_W'(count_reg) < SUM_W'(MAX_BLOCKS))
        begin
            regs.eff_count = LINK_W'(count_reg);
        end
        else
        begin
            regs.eff_count = LINK_W'(MAX_BLOCKS);
        end
    end

endmodule

// File: hw/rtl/bfl_div.sv
`timescale 1ns / 1ps

module bfl_div
    import bfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [UNIT_W-1:0] divisor,
    output logic              done,
    output logic [IDX_W-1:0]  quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [K_W-1:0]    k_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  q_reg;
    logic [UNIT_W-1:0] dsr_reg;
    logic [DIV_W-1:0]  shifted;

    assign shifted  = DIV_W'(dsr_reg) << k_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

    // Restoring division, one quotient bit per cycle from the top.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= K_W'(IDX_W - 1);
            end
            else if (busy_reg)
            begin
                if (k_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg - K_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            q_reg   <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg && (rem_reg >= shifted))
        begin
            rem_reg        <= rem_reg - shifted;
            q_reg[k_reg[K_W-1:0]] <= 1'b1;
        end
    end

endmodule

// File: hw/rtl/block_run_free_list_allocator.sv
// A free writes one link per block of the run; an allocation divides the length
// into blocks, then visits free-list candidates and checks the links of each.
// Item time is set by the walk over the link memory, one read per cycle.
// One item is in work at a time; a finished result waits in an output register.
// After reset a clearing pass over all MAX_BLOCKS entries initializes the link
// and run memories; no item is accepted until it ends.
`timescale 1ns / 1ps
`include "block_run_free_list_allocator_macros.svh"

module block_run_free_list_allocator
    import bfl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_PREP   = 4'd2;
    localparam logic [3:0] ST_ACHK   = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_CAND   = 4'd5;
    localparam logic [3:0] ST_LINK   = 4'd6;
    localparam logic [3:0] ST_COMMIT = 4'd7;
    localparam logic [3:0] ST_FCHK   = 4'd8;
    localparam logic [3:0] ST_FLINK  = 4'd9;
    localparam logic [3:0] ST_UPD    = 4'd10;
    localparam logic [3:0] ST_RESP   = 4'd11;

    cfg_t regs;

    logic [3:0]         state_reg;
    logic [IDX_W-1:0]   clr_reg;
    logic               kind_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [REL_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   lim_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [LINK_W-1:0]  n_reg;
    logic [CAP_W-1:0]   amt_reg;
    logic [LINK_W-1:0]  s_reg;
    logic [LINK_W-1:0]  prev_reg;
    logic [LINK_W-1:0]  i_reg;
    logic [LINK_W-1:0]  steps_reg;
    logic [LINK_W-1:0]  nxt_reg;
    logic               fit_reg;
    logic [LINK_W-1:0]  list_head_reg;
    logic [TOTAL_W-1:0] byte_total_reg;
    logic               ok_reg;
    logic [REL_W-1:0]   start_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               a_we;
    logic [IDX_W-1:0]   a_waddr;
    logic [LINK_W-1:0]  a_wdata;
    logic [IDX_W-1:0]   a_raddr;
    logic [LINK_W-1:0]  a_rdata;
    logic               b_we;
    logic [IDX_W-1:0]   b_waddr;
    logic [RUN_W-1:0]   b_wdata;
    logic [RUN_W-1:0]   b_rdata;

    logic               div_start;
    logic               div_done;
    logic [IDX_W-1:0]   div_q;
    logic [DIV_W-1:0]   dividend;

    logic [SUM_W-1:0]   eff_ext;
    logic [LEN_W:0]     len_ext;
    logic               alloc_fail;
    logic               free_ok;
    logic [LINK_W-1:0]  b_cnt;
    logic [SUM_W-1:0]   s_sum_i;
    logic [SUM_W-1:0]   f_sum_i;
    logic               fit;
    logic               last_i;
    logic               link_match;
    logic [LINK_W-1:0]  new_s;
    logic               new_s_end;

    bfl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    bfl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (regs.unit_bytes),
        .done     (div_done),
        .quotient (div_q)
    );

    bfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    bfl_ram #(
        .WIDTH (RUN_W),
        .DEPTH (MAX_BLOCKS)
    ) u_run_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (IDX_W'(idx_reg)),
        .rdata (b_rdata)
    );

    assign eff_ext  = SUM_W'(regs.eff_count);
    assign len_ext  = (LEN_W + 1)'(len_reg) + (LEN_W + 1)'(DESCRIPTOR_BYTES);
    assign dividend = DIV_W'(len_ext - (LEN_W + 1)'(1));

    assign alloc_fail = (len_reg == '0) || (len_reg >= lim_reg)
                     || (len_reg >= regs.region_bytes)
                     || (len_ext > (LEN_W + 1)'(cap_reg))
                     || (SUM_W'(list_head_reg) >= eff_ext);
    assign div_start  = (state_reg == ST_ACHK) && !alloc_fail;

    assign b_cnt   = b_rdata[LINK_W-1:0];
    assign free_ok = (SUM_W'(idx_reg) < eff_ext) && b_rdata[LINK_W] && (b_cnt != '0)
                  && ((SUM_W'(idx_reg) + SUM_W'(b_cnt)) <= eff_ext);

    assign s_sum_i    = SUM_W'(s_reg) + SUM_W'(i_reg) + SUM_W'(1);
    assign f_sum_i    = SUM_W'(idx_reg) + SUM_W'(i_reg);
    assign fit        = (SUM_W'(s_reg) + SUM_W'(n_reg)) <= eff_ext;
    assign last_i     = (i_reg == (n_reg - LINK_W'(1)));
    assign link_match = (SUM_W'(a_rdata) == s_sum_i);
    // Past the first link a mismatch means block s links to s + 1.
    assign new_s      = (i_reg == '0) ? a_rdata : LINK_W'(SUM_W'(s_reg) + SUM_W'(1));
    assign new_s_end  = (SUM_W'(new_s) >= eff_ext);

    always_comb
    begin
        a_we    = 1'b0;
        a_waddr = IDX_W'(s_reg);
        a_wdata = nxt_reg;
        a_raddr = IDX_W'(s_reg);
        b_we    = 1'b0;
        b_waddr = IDX_W'(s_reg);
        b_wdata = {1'b1, n_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                a_we    = 1'b1;
                a_waddr = clr_reg;
                a_wdata = LINK_W'(SUM_W'(clr_reg) + SUM_W'(1));
                b_we    = 1'b1;
                b_waddr = clr_reg;
                b_wdata = '0;
            end
            ST_LINK:
            begin
                if (fit_reg && !last_i && link_match)
                begin
                    a_raddr = IDX_W'(s_sum_i);
                end
            end
            ST_COMMIT:
            begin
                a_we    = (prev_reg != s_reg);
                a_waddr = IDX_W'(prev_reg);
                b_we    = 1'b1;
            end
            ST_FCHK:
            begin
                b_we    = free_ok;
                b_waddr = IDX_W'(idx_reg);
                b_wdata = {1'b0, b_cnt};
            end
            ST_FLINK:
            begin
                a_we    = 1'b1;
                a_waddr = IDX_W'(f_sum_i);
                a_wdata = last_i ? list_head_reg : LINK_W'(f_sum_i + SUM_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            list_head_reg  <= '0;
            byte_total_reg <= '0;
            rsp_valid_reg  <= 1'b0;
            i_reg          <= '0;
            steps_reg      <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == IDX_W'(MAX_BLOCKS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_valid && !req_stall)
                    begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    state_reg <= (kind_reg == KIND_FREE) ? ST_FCHK : ST_ACHK;
                end
                ST_ACHK:
                begin
                    if (alloc_fail)
                    begin
                        ok_reg    <= 1'b0;
                        start_reg <= '0;
                        state_reg <= ST_RESP;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_CAND;
                        s_reg     <= list_head_reg;
                        prev_reg  <= list_head_reg;
                        steps_reg <= '0;
                    end
                end
                ST_CAND:
                begin
                    fit_reg   <= fit;
                    i_reg     <= '0;
                    state_reg <= ST_LINK;
                end
                ST_LINK:
                begin
                    if (fit_reg && last_i)
                    begin
                        nxt_reg   <= a_rdata;
                        state_reg <= ST_COMMIT;
                    end
                    else if (fit_reg && link_match)
                    begin
                        i_reg <= i_reg + LINK_W'(1);
                    end
                    else
                    begin
                        prev_reg <= s_reg;
                        if (new_s_end || (steps_reg == LINK_W'(MAX_BLOCKS)))
                        begin
                            ok_reg    <= 1'b0;
                            start_reg <= '0;
                            state_reg <= ST_RESP;
                        end
                        else
                        begin
                            s_reg     <= new_s;
                            steps_reg <= steps_reg + LINK_W'(1);
                            state_reg <= ST_CAND;
                        end
                    end
                end
                ST_COMMIT:
                begin
                    if (prev_reg == s_reg)
                    begin
                        list_head_reg <= nxt_reg;
                    end
                    ok_reg    <= 1'b1;
                    start_reg <= REL_W'(s_reg);
                    state_reg <= ST_UPD;
                end
                ST_FCHK:
                begin
                    i_reg     <= '0;
                    ok_reg    <= free_ok;
                    start_reg <= '0;
                    state_reg <= free_ok ? ST_FLINK : ST_RESP;
                end
                ST_FLINK:
                begin
                    if (last_i)
                    begin
                        list_head_reg <= LINK_W'(idx_reg);
                        state_reg     <= ST_UPD;
                    end
                    else
                    begin
                        i_reg <= i_reg + LINK_W'(1);
                    end
                end
                ST_UPD:
                begin
                    if (kind_reg == KIND_FREE)
                    begin
                        byte_total_reg <= byte_total_reg - TOTAL_W'(amt_reg);
                    end
                    else
                    begin
                        byte_total_reg <= byte_total_reg + TOTAL_W'(amt_reg);
                    end
                    state_reg <= ST_RESP;
                end
                ST_RESP:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg <= CAP_W'(n_reg * regs.unit_bytes);
        if ((state_reg == ST_IDLE) && req_valid && !req_stall)
        begin
            kind_reg <= req.kind;
            len_reg  <= req.length_bytes;
            idx_reg  <= req.release_index;
        end
        if (state_reg == ST_PREP)
        begin
            lim_reg <= LEN_W'(regs.unit_bytes * UNIT_W'(RUN_LIMIT));
            cap_reg <= CAP_W'(regs.eff_count * regs.unit_bytes);
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            n_reg <= LINK_W'(div_q) + LINK_W'(1);
        end
        else if ((state_reg == ST_FCHK) && free_ok)
        begin
            n_reg <= b_cnt;
        end
        if ((state_reg == ST_RESP) && (!rsp_valid_reg || !rsp_stall))
        begin
            rsp_reg.ok           <= ok_reg;
            rsp_reg.run_start    <= start_reg;
            rsp_reg.bytes_in_use <= byte_total_reg;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `BFL_ASSERT_NOW(a_run_offset, (state_reg == ST_LINK) || (state_reg == ST_FLINK), i_reg < n_reg, "run offset beyond run length")
    `BFL_ASSERT_NEXT(a_total_hold, state_reg != ST_UPD, $stable(byte_total_reg), "byte total changed outside update")
    `BFL_ASSERT_NEXT(a_result_load, (state_reg == ST_RESP) && (!rsp_valid_reg || !rsp_stall), rsp_valid_reg && (state_reg == ST_IDLE), "result not loaded")

endmodule

// File: tb/block_run_free_list_allocator_test.sv
`timescale 1ns / 1ps

module block_run_free_list_allocator_test;
    import bfl_pkg::*;

    localparam int LONG_HOLD = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_t                  rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the allocator state and its settings.
    logic [UNIT_W-1:0]   shadow_unit;
    logic [REGION_W-1:0] shadow_region;
    logic [COUNT_W-1:0]  shadow_count;
    logic [LINK_W-1:0]   link_mem [MAX_BLOCKS];
    logic [LINK_W-1:0]   run_len [MAX_BLOCKS];
    logic                marked [MAX_BLOCKS];
    logic [LINK_W-1:0]   free_head;
    logic [TOTAL_W-1:0]  used_bytes;

    rsp_t             expected_results [$];
    logic [REL_W-1:0] live_heads [$];
    rsp_t             oldest_result;

    bit idle_on;
    int hold_requests;
    int hold_seen;
    int stall_left;
    int fail_count;
    int items_sent;
    int allocs_ok;
    int frees_ok;
    int settings_written;

    block_run_free_list_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint unsigned eff_blocks();
        return (shadow_count < MAX_BLOCKS) ? shadow_count : MAX_BLOCKS;
    endfunction

    function automatic logic try_allocate(input logic [LEN_W-1:0] len,
                                          output logic [REL_W-1:0] start);
        longint unsigned unit;
        longint unsigned limit;
        longint unsigned need;
        longint unsigned cur;
        longint unsigned prev;
        longint unsigned tail;
        int              hop;
        int              k;
        logic            hit;
        start = '0;
        unit = shadow_unit;
        limit = eff_blocks();
        if (len == 0 || len >= unit * RUN_LIMIT || len >= shadow_region)
            return 1'b0;
        need = (len + DESCRIPTOR_BYTES + unit - 1) / unit;
        if (need == 0 || need > limit)
            return 1'b0;
        cur = free_head;
        prev = cur;
        if (cur >= limit)
            return 1'b0;
        hit = 1'b0;
        for (hop = 0; hop <= MAX_BLOCKS; hop++)
        begin
            if (cur + need <= limit)
            begin
                hit = 1'b1;
                for (k = 0; k + 1 < need; k++)
                begin
                    if (link_mem[cur + k] != cur + k + 1)
                    begin
                        hit = 1'b0;
                        break;
                    end
                end
            end
            if (hit)
                break;
            prev = cur;
            cur = link_mem[cur];
            if (cur >= limit)
                return 1'b0;
        end
        if (!hit)
            return 1'b0;
        tail = link_mem[cur + need - 1];
        run_len[cur] = need;
        marked[cur] = 1'b1;
        if (prev == cur)
            free_head = tail;
        else
            link_mem[prev] = tail;
        used_bytes = used_bytes + need * unit;
        start = cur;
        live_heads.push_back(start);
        allocs_ok++;
        return 1'b1;
    endfunction

    function automatic logic try_release(input logic [REL_W-1:0] head);
        longint unsigned limit;
        longint unsigned cnt;
        int              k;
        limit = eff_blocks();
        if (head >= limit || !marked[head])
            return 1'b0;
        cnt = run_len[head];
        if (cnt == 0 || head + cnt > limit)
            return 1'b0;
        for (k = 0; k + 1 < cnt; k++)
            link_mem[head + k] = head + k + 1;
        link_mem[head + cnt - 1] = free_head;
        free_head = head;
        marked[head] = 1'b0;
        used_bytes = used_bytes - cnt * shadow_unit;
        for (k = 0; k < live_heads.size(); k++)
        begin
            if (live_heads[k] == head)
            begin
                live_heads.delete(k);
                break;
            end
        end
        frees_ok++;
        return 1'b1;
    endfunction

    function automatic rsp_t predict_outcome(input req_t item);
        rsp_t             outcome;
        logic [REL_W-1:0] start;
        logic             granted;
        start = '0;
        if (item.kind == KIND_ALLOC)
            granted = try_allocate(item.length_bytes, start);
        else
            granted = try_release(item.release_index);
        outcome.ok = granted;
        outcome.run_start = (item.kind == KIND_ALLOC && granted) ? start : '0;
        outcome.bytes_in_use = used_bytes;
        return outcome;
    endfunction

    function automatic req_t alloc_item(input logic [LEN_W-1:0] len);
        req_t item;
        item.kind = KIND_ALLOC;
        item.length_bytes = len;
        item.release_index = $urandom_range(0, MAX_BLOCKS - 1);
        return item;
    endfunction

    function automatic req_t free_item(input logic [REL_W-1:0] head);
        req_t item;
        item.kind = KIND_FREE;
        item.length_bytes = $urandom();
        item.release_index = head;
        return item;
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        longint unsigned unit;
        longint unsigned len;
        unit = shadow_unit;
        case ($urandom_range(0, 9))
            0: len = unit * $urandom_range(1, 8) - DESCRIPTOR_BYTES + $urandom_range(0, 1);
            1: len = $urandom_range(1, unit * 40);
            default: len = $urandom_range(1, unit * 6);
        endcase
        return len[LEN_W-1:0];
    endfunction

    function automatic req_t random_item();
        req_t        item;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            item.kind = $urandom_range(0, 1);
            item.length_bytes = $urandom();
            item.release_index = $urandom_range(0, MAX_BLOCKS - 1);
        end
        else if (pick < 50 && live_heads.size() > 0)
            item = free_item(live_heads[$urandom_range(0, live_heads.size() - 1)]);
        else if (pick < 55)
            item = free_item($urandom_range(0, MAX_BLOCKS - 1));
        else
            item = alloc_item(random_length());
        return item;
    endfunction

    task automatic send_item(input req_t item);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall);
        expected_results.push_back(predict_outcome(item));
        items_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] sel,
                                 input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (sel)
            CFG_UNIT: shadow_unit = value[UNIT_W-1:0];
            CFG_REGION: shadow_region = value[REGION_W-1:0];
            CFG_COUNT: shadow_count = value[COUNT_W-1:0];
            default: ;
        endcase
        settings_written++;
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] unit,
                                  input logic [CFG_DATA_W-1:0] region,
                                  input logic [CFG_DATA_W-1:0] count);
        wait_drained();
        write_setting(CFG_UNIT, unit);
        write_setting(CFG_REGION, region);
        write_setting(CFG_COUNT, count);
        cfg_valid <= 1'b0;
    endtask

    task automatic release_all();
        logic [REL_W-1:0] heads [$];
        heads = live_heads;
        foreach (heads[i])
            send_item(free_item(heads[i]));
    endtask

    task automatic test_settings_edges();
        apply_settings(4, 32'hFFFF_FFFF, 8);
        send_item(alloc_item(8));
        send_item(alloc_item(8));
        // The last two free blocks cannot hold three blocks before the end.
        send_item(alloc_item(8));
        send_item(alloc_item(262140));
        send_item(free_item(8));
        send_item(alloc_item(4));
        send_item(alloc_item(1));
        apply_settings(4, 32'hFFFF_FFFF, 7);
        send_item(free_item(6));
        // Freeing with a larger block size drives the byte counter below zero.
        apply_settings(65535, 32'hFFFF_FFFF, 8);
        send_item(free_item(0));
        send_item(alloc_item(65531));
        apply_settings(65535, 0, 1);
        send_item(alloc_item(1));
        send_item(free_item(3));
        apply_settings(UNIT_RESET, REGION_RESET, COUNT_RESET);
        release_all();
    endtask

    task automatic test_request_checks();
        logic [REL_W-1:0] first_head;
        send_item(alloc_item(0));
        send_item(alloc_item(32'hFFFF_FFFF));
        send_item(alloc_item(16384));
        send_item(alloc_item(16383));
        send_item(alloc_item(1));
        first_head = (live_heads.size() > 0) ? live_heads[0] : '0;
        send_item(alloc_item(13));
        send_item(alloc_item(4000));
        send_item(free_item(live_heads[$] + 1));
        send_item(free_item(MAX_BLOCKS - 1));
        send_item(free_item(first_head));
        send_item(free_item(first_head));
        send_item(alloc_item(20));
        release_all();
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_on = 1'b1;
                    apply_settings(UNIT_RESET, REGION_RESET, COUNT_RESET);
                end
                1:
                begin
                    idle_on = 1'b0;
                    apply_settings(4, 32'hFFFF_FFFF, MAX_BLOCKS);
                end
                2:
                begin
                    idle_on = 1'b1;
                    apply_settings(65535, $urandom_range(32'h0001_0000, 32'hFFFF_FFFF),
                                   $urandom_range(2, 64));
                end
                3: apply_settings($urandom_range(4, 512),
                                  $urandom_range(32'h0000_1000, 32'hFFFF_FFFF),
                                  $urandom_range(1, MAX_BLOCKS));
                default: apply_settings(UNIT_RESET, REGION_RESET, COUNT_RESET);
            endcase
            repeat (70) send_item(random_item());
            release_all();
        end
    endtask

    task automatic test_output_backpressure();
        idle_on = 1'b0;
        hold_requests <= hold_requests + 1;
        repeat (24) send_item(random_item());
        wait_drained();
        idle_on = 1'b1;
        release_all();
    endtask

    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            stall_left = LONG_HOLD;
        end
        else if (rsp_valid && !rsp_stall)
            stall_left = idle_on ? $urandom_range(0, 12) : 0;
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result arrived with no item outstanding");
                fail_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (rsp.ok !== oldest_result.ok)
                begin
                    $error("ok: expected %0d, got %0d", oldest_result.ok, rsp.ok);
                    fail_count++;
                end
                if (rsp.run_start !== oldest_result.run_start)
                begin
                    $error("run_start: expected %0d, got %0d",
                           oldest_result.run_start, rsp.run_start);
                    fail_count++;
                end
                if (rsp.bytes_in_use !== oldest_result.bytes_in_use)
                begin
                    $error("bytes_in_use: expected %0d, got %0d",
                           oldest_result.bytes_in_use, rsp.bytes_in_use);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_on = 1'b1;
        shadow_unit = UNIT_RESET;
        shadow_region = REGION_RESET;
        shadow_count = COUNT_RESET;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            link_mem[i] = i + 1;
            run_len[i] = '0;
            marked[i] = 1'b0;
        end
        free_head = '0;
        used_bytes = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_settings_edges();
        test_request_checks();
        test_random_traffic();
        test_output_backpressure();

        wait_drained();
        repeat (64) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end
        $display("Ran %0d allocate and free items across %0d register writes.",
                 items_sent, settings_written);
        $display("%0d allocations and %0d releases succeeded; %0d mismatches seen.",
                 allocs_ok, frees_ok, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
